@@ src/nfms_pkg.sv @@
`timescale 1ns / 1ps

package nfms_pkg;

   // Default geometry of the block.
   localparam int PATTERN_MAX_DEF   = 64;
   localparam int POSITION_BITS_DEF = 32;

   // Fixed field widths.
   localparam int BYTE_W      = 8;
   localparam int SLOT_W      = 6;
   localparam int CFG_W       = 7;
   localparam int OUT_POS_W   = 32;
   localparam int COUNT_W     = 38;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 72;

   // Lanes per group in the leading-match encoder.
   localparam int GROUP_W     = 8;
   localparam int GROUP_IDX_W = 3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   // Operation carried in tuser.
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_TEXT = 1'b1;

endpackage

@@ src/nfms_align_compare.sv @@
`timescale 1ns / 1ps

// Lines the newest m window bytes up against the pattern and compares them
// byte by byte. Lanes at or beyond m, and padding lanes, report a match so
// that only a genuine mismatch stops the leading-match count.
module nfms_align_compare #(
   parameter int PATTERN_MAX = nfms_pkg::PATTERN_MAX_DEF,
   parameter int LEN_W       = $clog2(nfms_pkg::PATTERN_MAX_DEF + 1),
   parameter int EQ_W        = nfms_pkg::PATTERN_MAX_DEF
) (
   input  logic [PATTERN_MAX*nfms_pkg::BYTE_W-1:0] window,
   input  logic [PATTERN_MAX*nfms_pkg::BYTE_W-1:0] pattern,
   input  logic [LEN_W-1:0]                        length,
   output logic [EQ_W-1:0]                         equal
);

   localparam int WIN_W = PATTERN_MAX * nfms_pkg::BYTE_W;

   logic [LEN_W-1:0]   skip_bytes;
   logic [LEN_W+2:0]   shift_bits;
   logic [WIN_W-1:0]   aligned;

   // The oldest byte sits in the lowest lane, so dropping PATTERN_MAX - m
   // bytes leaves the alignment under judgement starting at lane 0.
   assign skip_bytes = LEN_W'(PATTERN_MAX) - length;
   assign shift_bits = {skip_bytes, 3'b000};
   assign aligned    = window >> shift_bits;

   always_comb begin
      equal = '1;
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (LEN_W'(k) < length) begin
            equal[k] = (aligned[k*nfms_pkg::BYTE_W +: nfms_pkg::BYTE_W] ==
                        pattern[k*nfms_pkg::BYTE_W +: nfms_pkg::BYTE_W]);
         end
      end
   end

endmodule

@@ src/naive_first_match_search.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Payload
// req       in         req_tvalid/tready     tdata: byte_value, pattern_slot; tuser: op;
//                                            tlast: last_text
// rsp       out        rsp_tvalid/tready     tdata: found, match_position, comparison_count
// csr       in         csr_valid/csr_ready   csr_data: pattern_length
//
// One transaction is taken every cycle unless an rsp stall holds the pipeline. A text
// byte passes a four-stage pipeline (window, byte compare, group encode, leading-match
// combine) and its count is folded into the search state as it leaves; the result is
// registered in the output register as the final text byte leaves the last stage.
// Reset is synchronous and needs no clearing pass; the pattern store holds
// nothing defined until loaded. A stall on rsp only holds the pipeline once a
// second final byte reaches the last stage behind an untaken result.
module naive_first_match_search #(
   parameter int PATTERN_MAX   = nfms_pkg::PATTERN_MAX_DEF,
   parameter int POSITION_BITS = nfms_pkg::POSITION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [7:0] byte_value, [13:8] pattern_slot, [15:14] zero
   input  logic [nfms_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] op
   input  logic                              req_tuser,
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [0] found, [32:1] match_position, [70:33] comparison_count, [71] zero
   output logic [nfms_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nfms_pkg::CFG_W-1:0]        csr_data
);

   localparam int BYTE_W  = nfms_pkg::BYTE_W;
   localparam int WIN_W   = PATTERN_MAX * BYTE_W;
   localparam int LEN_W   = $clog2(PATTERN_MAX + 1);
   localparam int LW      = (LEN_W > nfms_pkg::CFG_W) ? LEN_W : nfms_pkg::CFG_W;
   localparam int N_GRP   = (PATTERN_MAX + nfms_pkg::GROUP_W - 1) / nfms_pkg::GROUP_W;
   localparam int EQ_W    = N_GRP * nfms_pkg::GROUP_W;
   localparam int COUNT_W = nfms_pkg::COUNT_W;

   // Configuration
   logic [nfms_pkg::CFG_W-1:0] len_ff;
   logic [LW-1:0]              len_wide;
   logic [LEN_W-1:0]           m_eff;

   // Storage
   logic [WIN_W-1:0] win_ff, win_in;
   logic [WIN_W-1:0] pat_ff;

   // Pipeline control
   logic req_fire, req_is_text;
   logic s1_ready, s2_ready, s3_ready, s4_ready, s4_go, s4_fire;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic s1_last_ff, s2_last_ff, s3_last_ff, s4_last_ff;

   // Pipeline payload
   logic [EQ_W-1:0]                    eq_in, eq_ff;
   logic [N_GRP-1:0]                   grp_full_in, grp_full_ff;
   logic [nfms_pkg::GROUP_IDX_W-1:0]   grp_idx_in [N_GRP];
   logic [nfms_pkg::GROUP_IDX_W-1:0]   grp_idx_ff [N_GRP];
   logic                               full_in, full_ff;
   logic [LEN_W-1:0]                   cost_in, cost_ff;

   // Search state
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] off_ff, off_in;
   logic [COUNT_W-1:0]       cnt_ff, cnt_in;
   logic                     seen_ff, seen_in;

   // Result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [nfms_pkg::RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;

   assign csr_ready = 1'b1;

   assign len_wide = LW'(len_ff);
   assign m_eff    = (len_wide > LW'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : LEN_W'(len_wide);

   // Ready chain: the last stage only holds a final byte while the output
   // register is occupied and not being drained.
   assign s4_go      = !s4_last_ff || !rsp_valid_ff || rsp_tready;
   assign s4_fire    = s4_valid_ff && s4_go;
   assign s4_ready   = !s4_valid_ff || s4_go;
   assign s3_ready   = !s3_valid_ff || s4_ready;
   assign s2_ready   = !s2_valid_ff || s3_ready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;

   assign req_fire    = req_tvalid && req_tready;
   assign req_is_text = (req_tuser == nfms_pkg::OP_TEXT);

   always_comb begin
      win_in = win_ff >> BYTE_W;
      win_in[WIN_W-1 -: BYTE_W] = req_tdata[BYTE_W-1:0];
   end

   nfms_align_compare #(
      .PATTERN_MAX (PATTERN_MAX),
      .LEN_W       (LEN_W),
      .EQ_W        (EQ_W)
   ) u_align (
      .window  (win_ff),
      .pattern (pat_ff),
      .length  (m_eff),
      .equal   (eq_in)
   );

   // First mismatching lane inside each group of eight.
   always_comb begin
      for (int g = 0; g < N_GRP; g++) begin
         grp_full_in[g] = &eq_ff[g*nfms_pkg::GROUP_W +: nfms_pkg::GROUP_W];
         grp_idx_in[g]  = '0;
         for (int j = nfms_pkg::GROUP_W - 1; j >= 0; j--) begin
            if (!eq_ff[g*nfms_pkg::GROUP_W + j]) begin
               grp_idx_in[g] = nfms_pkg::GROUP_IDX_W'(j);
            end
         end
      end
   end

   // Leading matching bytes k across the groups; a mismatch costs k + 1.
   always_comb begin
      int k_int;
      k_int = 0;
      for (int g = N_GRP - 1; g >= 0; g--) begin
         if (!grp_full_ff[g]) begin
            k_int = g * nfms_pkg::GROUP_W + int'(grp_idx_ff[g]);
         end
      end
      full_in = &grp_full_ff;
      cost_in = full_in ? m_eff : LEN_W'(k_int + 1);
   end

   // Fold the judged alignment into the search state.
   always_comb begin
      logic [POSITION_BITS:0] p_next;
      logic [POSITION_BITS:0] m_ext;
      logic [LEN_W-1:0]       add;
      logic [COUNT_W:0]       sum;
      p_next  = {1'b0, pos_ff} + (POSITION_BITS + 1)'(1);
      m_ext   = (POSITION_BITS + 1)'(m_eff);
      add     = '0;
      seen_in = seen_ff;
      off_in  = off_ff;
      if (!seen_ff) begin
         if (m_eff == '0) begin
            seen_in = 1'b1;
            off_in  = '0;
         end else if (p_next >= m_ext) begin
            add = cost_ff;
            if (full_ff) begin
               seen_in = 1'b1;
               off_in  = POSITION_BITS'(p_next - m_ext);
            end
         end
      end
      sum    = {1'b0, cnt_ff} + (COUNT_W + 1)'(add);
      cnt_in = (sum > {1'b0, nfms_pkg::COUNT_MAX}) ? nfms_pkg::COUNT_MAX : sum[COUNT_W-1:0];
      pos_in = (&pos_ff) ? pos_ff : p_next[POSITION_BITS-1:0];

      rsp_data_in = {1'b0, cnt_in,
                     seen_in ? nfms_pkg::OUT_POS_W'(off_in) : {nfms_pkg::OUT_POS_W{1'b0}},
                     seen_in};
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (s4_fire && s4_last_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff       <= '0;
         win_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         pos_ff       <= '0;
         off_ff       <= '0;
         cnt_ff       <= '0;
         seen_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            len_ff <= csr_data;
         end

         if (req_fire && req_is_text) begin
            win_ff <= win_in;
         end

         if (s1_ready) begin
            s1_valid_ff <= req_fire && req_is_text;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_ready) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (s4_ready) begin
            s4_valid_ff <= s3_valid_ff;
         end

         if (s4_fire) begin
            if (s4_last_ff) begin
               pos_ff  <= '0;
               off_ff  <= '0;
               cnt_ff  <= '0;
               seen_ff <= 1'b0;
            end else begin
               pos_ff  <= pos_in;
               off_ff  <= off_in;
               cnt_ff  <= cnt_in;
               seen_ff <= seen_in;
            end
         end

         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers, no reset.
   always_ff @(posedge clock) begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if (req_fire && !req_is_text && 32'(req_tdata[BYTE_W +: nfms_pkg::SLOT_W]) == i) begin
            pat_ff[i*BYTE_W +: BYTE_W] <= req_tdata[BYTE_W-1:0];
         end
      end
      if (s1_ready) begin
         s1_last_ff <= req_tlast;
      end
      if (s2_ready) begin
         s2_last_ff <= s1_last_ff;
         eq_ff      <= eq_in;
      end
      if (s3_ready) begin
         s3_last_ff  <= s2_last_ff;
         grp_full_ff <= grp_full_in;
         grp_idx_ff  <= grp_idx_in;
      end
      if (s4_ready) begin
         s4_last_ff <= s3_last_ff;
         full_ff    <= full_in;
         cost_ff    <= cost_in;
      end
      if (s4_fire && s4_last_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
